// ===== hdl/nvm_transaction_queue_top_macros.svh =====
// Assertion macros for the transaction queue top level.
`ifndef NVM_TRANSACTION_QUEUE_TOP_MACROS_SVH
`define NVM_TRANSACTION_QUEUE_TOP_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define NTQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define NTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ntq_pkg.sv =====
// Shared types, constants and a helper function for the transaction queue.
package ntq_pkg;

  // Number of transaction slots and the width of a slot index.
  localparam int SLOTS = 4;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Request codes.
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_SERVICE = 3'd2;
  localparam logic [2:0] REQ_READY   = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;

  // Memory command codes.
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] mem_addr;
    logic [15:0] buf_base;
    logic [7:0]  byte_count;
    logic [7:0]  tx_id;
  } in_req_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  new_id;
    logic        done_flag;
    logic [1:0]  cmd;
    logic [15:0] cmd_mem_addr;
    logic [15:0] cmd_buf_addr;
    logic [7:0]  cmd_length;
    logic        ready_enable;
  } out_res_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] buffer;
    logic [7:0]  count;
    logic [7:0]  position;
  } slot_entry_t;

  // Slot index plus an offset, wrapping at the number of slots.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W:0]   offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + offs;
    if (sum >= (IDX_W+1)'(SLOTS)) begin
      sum = sum - (IDX_W+1)'(SLOTS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/nvm_transaction_queue_top.sv =====
// Slotted read/write transaction queue for a byte-wide nonvolatile memory.
// A query, clear, refused submit or ignored request passes through S_EXEC and S_DONE; a
// write-driving memory-ready adds S_RDY_WB, a service or accepted submit adds S_SVC and, if a
// slot is picked, S_SVC_WB. A new request is taken only after the last result is handed to the
// output register, which waits while the result side stalls. Synchronous active-low reset clears
// flags, ids, head and id counter; the slot memory is never read before written.
module nvm_transaction_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ntq_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ntq_pkg::out_res_t  out_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SVC    = 3'd2;
  localparam logic [2:0] S_SVC_WB = 3'd3;
  localparam logic [2:0] S_RDY_WB = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // Control state.
  logic [2:0]                        state_r, state_nxt;
  logic [7:0]                        ident_r [ntq_pkg::SLOTS];
  logic [7:0]                        ident_nxt [ntq_pkg::SLOTS];
  logic [ntq_pkg::SLOTS-1:0]         active_r, active_nxt;
  logic [ntq_pkg::SLOTS-1:0]         done_r, done_nxt;
  logic [ntq_pkg::SLOTS-1:0]         is_write_r, is_write_nxt;
  logic [ntq_pkg::IDX_W-1:0]         head_r, head_nxt;
  logic [7:0]                        next_id_r, next_id_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Payload registers.
  ntq_pkg::in_req_t                  req_r, req_nxt;
  ntq_pkg::out_res_t                 res_r, res_nxt;
  ntq_pkg::out_res_t                 out_data_r, out_data_nxt;
  logic [ntq_pkg::IDX_W-1:0]         sel_r, sel_nxt;

  // Slot memory and its ports.
  ntq_pkg::slot_entry_t              slot_mem [ntq_pkg::SLOTS];
  ntq_pkg::slot_entry_t              rd_data_r;
  ntq_pkg::slot_entry_t              mem_wd;
  logic                              mem_we;
  logic [ntq_pkg::IDX_W-1:0]         mem_wa, mem_ra;

  // Slot searches.
  logic                              free_found, pend_found, match_found;
  logic [ntq_pkg::IDX_W-1:0]         free_idx, pend_idx, match_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Free and pending slot searches, starting at the head and wrapping.
  always_comb begin
    logic [ntq_pkg::IDX_W-1:0] idx;
    free_found = 1'b0;
    free_idx   = '0;
    pend_found = 1'b0;
    pend_idx   = '0;
    for (int k = 0; k < ntq_pkg::SLOTS; k++) begin
      idx = ntq_pkg::wrap_add(head_r, (ntq_pkg::IDX_W+1)'(k));
      if (!free_found && ident_r[idx] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = idx;
      end
      if (!pend_found && ident_r[idx] != 8'd0 && !active_r[idx] && !done_r[idx]) begin
        pend_found = 1'b1;
        pend_idx   = idx;
      end
    end
  end

  // Lowest-numbered slot whose id matches the requested one.
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int k = ntq_pkg::SLOTS - 1; k >= 0; k--) begin
      if (ident_r[k] == req_r.tx_id) begin
        match_found = 1'b1;
        match_idx   = ntq_pkg::IDX_W'(k);
      end
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt     = state_r;
    ident_nxt     = ident_r;
    active_nxt    = active_r;
    done_nxt      = done_r;
    is_write_nxt  = is_write_r;
    head_nxt      = head_r;
    next_id_nxt   = next_id_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    sel_nxt       = sel_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = sel_r;
    mem_wd        = rd_data_r;
    mem_ra        = sel_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          res_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (req_r.req_type)
          ntq_pkg::REQ_WRITE, ntq_pkg::REQ_READ: begin
            if (!free_found) begin
              res_nxt.status = 1'b1;
            end else begin
              // Stamp the free slot and store its transaction.
              ident_nxt[free_idx]    = next_id_r;
              res_nxt.new_id         = next_id_r;
              next_id_nxt            = (next_id_r == 8'hFF) ? 8'd1 : next_id_r + 8'd1;
              is_write_nxt[free_idx] = (req_r.req_type == ntq_pkg::REQ_WRITE);
              active_nxt[free_idx]   = 1'b0;
              done_nxt[free_idx]     = 1'b0;
              mem_we                 = 1'b1;
              mem_wa                 = free_idx;
              mem_wd.start           = req_r.mem_addr;
              mem_wd.buffer          = req_r.buf_base;
              mem_wd.count           = req_r.byte_count;
              mem_wd.position        = 8'd0;
              state_nxt              = S_SVC;
            end
          end
          ntq_pkg::REQ_SERVICE: begin
            state_nxt = S_SVC;
          end
          ntq_pkg::REQ_READY: begin
            if (active_r[head_r] && is_write_r[head_r]) begin
              sel_nxt   = head_r;
              mem_ra    = head_r;
              state_nxt = S_RDY_WB;
            end
          end
          ntq_pkg::REQ_QUERY: begin
            res_nxt.done_flag = match_found ? done_r[match_idx] : 1'b1;
          end
          ntq_pkg::REQ_CLEAR: begin
            if (match_found && !active_r[match_idx]) begin
              ident_nxt[match_idx] = 8'd0;
            end else begin
              res_nxt.status = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // Pick the next pending slot unless the head is still busy.
      S_SVC: begin
        if (!active_r[head_r] && pend_found) begin
          sel_nxt   = pend_idx;
          mem_ra    = pend_idx;
          state_nxt = S_SVC_WB;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Issue the first command of the chosen slot and write its position back.
      S_SVC_WB: begin
        res_nxt.cmd_mem_addr = rd_data_r.start + {8'd0, rd_data_r.position};
        res_nxt.cmd_buf_addr = rd_data_r.buffer + {8'd0, rd_data_r.position};
        mem_we = 1'b1;
        if (is_write_r[sel_r]) begin
          res_nxt.cmd        = ntq_pkg::CMD_WRITE;
          mem_wd.position    = rd_data_r.position + 8'd1;
          active_nxt[sel_r]  = 1'b1;
          head_nxt           = sel_r;
        end else begin
          res_nxt.cmd        = ntq_pkg::CMD_READ;
          res_nxt.cmd_length = rd_data_r.count;
          mem_wd.position    = rd_data_r.count;
          done_nxt[sel_r]    = 1'b1;
          head_nxt           = ntq_pkg::wrap_add(sel_r, (ntq_pkg::IDX_W+1)'(1));
        end
        state_nxt = S_DONE;
      end

      // Next byte of the active write, or completion after the last one.
      S_RDY_WB: begin
        if (rd_data_r.position < rd_data_r.count) begin
          res_nxt.cmd          = ntq_pkg::CMD_WRITE;
          res_nxt.cmd_mem_addr = rd_data_r.start + {8'd0, rd_data_r.position};
          res_nxt.cmd_buf_addr = rd_data_r.buffer + {8'd0, rd_data_r.position};
          mem_we               = 1'b1;
          mem_wd.position      = rd_data_r.position + 8'd1;
        end else begin
          done_nxt[sel_r]   = 1'b1;
          active_nxt[sel_r] = 1'b0;
          head_nxt          = ntq_pkg::wrap_add(sel_r, (ntq_pkg::IDX_W+1)'(1));
        end
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt              = res_r;
          out_data_nxt.ready_enable = active_r[head_r] && is_write_r[head_r];
          out_valid_nxt             = 1'b1;
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      done_r      <= '0;
      is_write_r  <= '0;
      head_r      <= '0;
      next_id_r   <= 8'd1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < ntq_pkg::SLOTS; k++) begin
        ident_r[k] <= 8'd0;
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      done_r      <= done_nxt;
      is_write_r  <= is_write_nxt;
      head_r      <= head_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      ident_r     <= ident_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    sel_r      <= sel_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= slot_mem[mem_ra];
  end

`include "nvm_transaction_queue_top_macros.svh"

  // Only the head slot may ever be active, and at most one at a time.
  `NTQ_ASSERT_SAME(a_one_active, 1'b1, $onehot0(active_r), "more than one slot active")
  `NTQ_ASSERT_SAME(a_active_is_head, active_r != '0, active_r[head_r], "active slot not at head")
  // An accepted request always starts the sequencer.
  `NTQ_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == S_EXEC,
                   "accepted request did not start")

endmodule
